FILE: design/tdwq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tdwq_pkg;
    localparam int DefQueueDepth = 16;

    typedef enum logic [1:0] {
        ACT_READ = 2'd0,
        ACT_REL  = 2'd1,
        ACT_ABS  = 2'd2,
        ACT_TICK = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_TIME = 2'd0,
        KIND_WAKE = 2'd1,
        KIND_ACK  = 2'd2,
        KIND_FULL = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  task_id;
        logic [31:0] tick_value;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  target_task;
        logic [31:0] time_now;
        logic        last;
    } t_out;

    // Classified request handed from the front part to the back part
    typedef struct packed {
        t_action     action;
        logic [7:0]  task_id;
        logic [31:0] wake;
    } t_cmd;
endpackage
`default_nettype wire

FILE: design/tdwq_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Front part: take requests, compute the wake time, hold a small command queue.
module tdwq_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  tdwq_pkg::t_in      i_data,
    input  wire logic [31:0]   i_tick_count,
    input  wire logic          i_tick_pend,
    output logic               o_cmd_valid,
    input  wire logic          i_cmd_ready,
    output tdwq_pkg::t_cmd     o_cmd
);
    import tdwq_pkg::*;

    // Two-entry queue
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       r_tick_in;
    t_cmd       w_cmd;
    logic       w_push, w_pop;

    // A relative delay needs the count as left by all earlier ticks, so no
    // relative delay passes a tick that is still queued or in the back part.
    always_comb begin
        w_cmd.action  = t_action'(i_data.action);
        w_cmd.task_id = i_data.task_id;
        w_cmd.wake    = (i_data.action == ACT_REL) ? i_tick_count + i_data.tick_value
                                                   : i_data.tick_value;
        o_ready = (r_cnt != 2'd2) &&
                  !((i_data.action == ACT_REL) && (r_tick_in || i_tick_pend));
    end

    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    // Store command payload
    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cmd;
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0; r_tick_in <= 1'b0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
            // Track whether any tick sits in the queue
            if (w_push && i_data.action == ACT_TICK) r_tick_in <= 1'b1;
            else if (w_pop && r_cnt == 2'd1) r_tick_in <= 1'b0;
            else if (w_pop && o_cmd.action == ACT_TICK
                     && r_q[~r_rp].action != ACT_TICK) r_tick_in <= 1'b0;
        end
    end
endmodule
`default_nettype wire

FILE: design/tdwq_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Back part: ordered store, tick count and result sequencing.
module tdwq_back #(
    parameter int QUEUE_DEPTH = tdwq_pkg::DefQueueDepth
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cmd_valid,
    output logic             o_cmd_ready,
    input  tdwq_pkg::t_cmd   i_cmd,
    output logic [31:0]      o_tick_count,
    output logic             o_tick_pend,
    output logic             o_valid,
    input  wire logic        i_ready,
    output tdwq_pkg::t_out   o_data
);
    import tdwq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_INS  = 4'b0010,
        ST_REL  = 4'b0100,
        ST_ACK  = 4'b1000
    } t_state;

    // Entries kept sorted in a register file; shift-insert and shift-out
    logic [7:0]  r_task [QUEUE_DEPTH];
    logic [31:0] r_wake [QUEUE_DEPTH];
    logic [CW-1:0] r_cnt;
    logic [31:0] r_tick;
    t_state      r_st;
    t_cmd        r_cmd;
    logic        r_ov;
    t_out        r_out;
    logic        w_full, w_front_due, w_out_free;
    logic [QUEUE_DEPTH-1:0] w_gt;

    assign w_full       = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_cmd_ready  = (r_st == ST_IDLE) && !r_ov;
    assign o_tick_count = r_tick;
    assign o_tick_pend  = (r_st != ST_IDLE);
    assign o_valid      = r_ov;
    assign o_data       = r_out;
    assign w_front_due  = (r_cnt != '0) && (r_wake[0] <= r_tick);
    assign w_out_free   = !r_ov || i_ready;

    // Per-slot compare for insert position: slot moves up if later than new
    always_comb begin
        for (int k = 0; k < QUEUE_DEPTH; k++)
            w_gt[k] = (CW'(k) < r_cnt) && (r_wake[k] > r_cmd.wake);
    end

    // Storage shift
    always_ff @(posedge i_clk) begin
        if (r_st == ST_INS && !w_full) begin
            for (int k = 0; k < QUEUE_DEPTH; k++) begin
                if (k > 0 && w_gt[k-1]) begin
                    r_task[k] <= r_task[k-1];
                    r_wake[k] <= r_wake[k-1];
                end
                // place new entry at first greater slot or at the end
                if ((w_gt[k] && (k == 0 || !w_gt[k-1])) ||
                    (w_gt == '0 && CW'(k) == r_cnt)) begin
                    r_task[k] <= r_cmd.task_id;
                    r_wake[k] <= r_cmd.wake;
                end
            end
        end else if (r_st == ST_REL && w_front_due && w_out_free) begin
            for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
                r_task[k] <= r_task[k+1];
                r_wake[k] <= r_wake[k+1];
            end
        end
    end

    // Sequence one command and its results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_cnt <= '0; r_tick <= '0; r_ov <= 1'b0;
        end else begin
            unique case (r_st)
                ST_IDLE: begin
                    if (i_cmd_valid && !r_ov) begin
                        r_cmd <= i_cmd;
                        unique case (i_cmd.action) inside
                            ACT_READ: begin
                                r_ov  <= 1'b1;
                                r_out <= '{KIND_TIME, i_cmd.task_id, r_tick, 1'b1};
                            end
                            ACT_REL, ACT_ABS: r_st <= ST_INS;
                            ACT_TICK: begin
                                r_tick <= r_tick + 32'd1;
                                r_st   <= ST_REL;
                            end
                            default: r_st <= ST_IDLE;
                        endcase
                    end else if (r_ov && i_ready) begin
                        r_ov <= 1'b0;
                    end
                end
                ST_INS: begin
                    if (w_full) begin
                        r_ov  <= 1'b1;
                        r_out <= '{KIND_FULL, r_cmd.task_id, r_tick, 1'b1};
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    r_st <= ST_IDLE;
                end
                ST_REL: begin
                    if (w_out_free) begin
                        if (w_front_due) begin
                            r_ov  <= 1'b1;
                            r_out <= '{KIND_WAKE, r_task[0], r_tick, 1'b0};
                            r_cnt <= r_cnt - CW'(1);
                        end else begin
                            r_ov <= 1'b0;
                            r_st <= ST_ACK;
                        end
                    end
                end
                ST_ACK: begin
                    if (w_out_free) begin
                        r_ov  <= 1'b1;
                        r_out <= '{KIND_ACK, r_cmd.task_id, r_tick, 1'b1};
                        r_st  <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: design/tick_delay_wakeup_queue_core.sv
// Path from request accept to result: the front queue registers the request and the
// back part registers the result; a tick acknowledgment follows its wake results.
// The back part takes a new read time, delay or tick only when it is done with the
// last command and holds no result; a stalled result holds it.
// Reset (synchronous, active low) clears the tick count, the entry count and
// both queues; stored entries are left as they are.
`timescale 1ns / 1ps
`default_nettype none
module tick_delay_wakeup_queue_core #(
    parameter int QUEUE_DEPTH = tdwq_pkg::DefQueueDepth
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  tdwq_pkg::t_in  i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output tdwq_pkg::t_out o_data
);
    import tdwq_pkg::*;

    t_cmd        w_cmd;
    logic        w_cmd_valid, w_cmd_ready, w_tick_pend;
    logic [31:0] w_tick;

    // Front part
    tdwq_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .i_tick_count(w_tick), .i_tick_pend(w_tick_pend),
        .o_cmd_valid(w_cmd_valid), .i_cmd_ready(w_cmd_ready), .o_cmd(w_cmd)
    );

    // Back part
    tdwq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(w_cmd_valid), .o_cmd_ready(w_cmd_ready), .i_cmd(w_cmd),
        .o_tick_count(w_tick), .o_tick_pend(w_tick_pend),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );
endmodule
`default_nettype wire

FILE: design/tdwq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module tdwq_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_valid,
    input wire logic           o_ready,
    input tdwq_pkg::t_in       i_data,
    input wire logic           o_valid,
    input wire logic           i_ready,
    input tdwq_pkg::t_out      o_data
);
    import tdwq_pkg::*;

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    // Wake results are never marked last
    a_wake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.kind == KIND_WAKE |-> !o_data.last)
        else $error("wake marked last");

    // Other kinds are always last
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.kind != KIND_WAKE |-> o_data.last)
        else $error("final result not marked last");

    // Nothing comes out right after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result after reset");
endmodule

bind tick_delay_wakeup_queue_core tdwq_checker u_chk (.*);
`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import tdwq_pkg::*;

    localparam int Depth = DefQueueDepth;
    localparam int CycleLimit = 400000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in i_data;
    logic o_valid;
    logic i_ready;
    t_out o_data;

    tick_delay_wakeup_queue_core uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    // Predicted timer state
    logic [31:0] now_ticks;
    logic [7:0] sleeper_task[$];
    logic [31:0] sleeper_wake[$];
    t_out pending_replies[$];

    int errors;
    int cycles;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off;
    bit draining;

    // Directed table: request plus an optional typed-in reply
    typedef struct {
        t_in req;
        bit has_fixed;
        t_out fixed;
    } t_row;
    t_row rows[$];

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Advance the predicted state by one request and queue its replies
    function automatic void predict_request(input t_in req);
        logic [31:0] wake;
        int pos;
        t_out r;
        case (t_action'(req.action)) inside
            ACT_READ: begin
                r = '{KIND_TIME, req.task_id, now_ticks, 1'b1};
                pending_replies.push_back(r);
            end
            ACT_REL, ACT_ABS: begin
                wake = (t_action'(req.action) == ACT_REL) ? now_ticks + req.tick_value
                                                          : req.tick_value;
                if (sleeper_task.size() >= Depth) begin
                    r = '{KIND_FULL, req.task_id, now_ticks, 1'b1};
                    pending_replies.push_back(r);
                end else begin
                    pos = 0;
                    while (pos < sleeper_wake.size() && sleeper_wake[pos] <= wake)
                        pos++;
                    sleeper_task.insert(pos, req.task_id);
                    sleeper_wake.insert(pos, wake);
                end
            end
            default: begin
                now_ticks = now_ticks + 32'd1;
                while (sleeper_wake.size() > 0 && sleeper_wake[0] <= now_ticks) begin
                    r = '{KIND_WAKE, sleeper_task[0], now_ticks, 1'b0};
                    pending_replies.push_back(r);
                    void'(sleeper_task.pop_front());
                    void'(sleeper_wake.pop_front());
                end
                r = '{KIND_ACK, req.task_id, now_ticks, 1'b1};
                pending_replies.push_back(r);
            end
        endcase
    endfunction

    // Check each reply against the oldest prediction
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected reply %p", $time, o_data);
                errors++;
            end else begin
                exp_r = pending_replies.pop_front();
                if (o_data.kind !== exp_r.kind || o_data.target_task !== exp_r.target_task
                    || o_data.time_now !== exp_r.time_now || o_data.last !== exp_r.last) begin
                    $display("%0t: mismatch expected %p actual %p", $time, exp_r, o_data);
                    errors++;
                end
            end
        end
    end

    // Receiver backpressure
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            i_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_request(input t_in req);
        while (!draining && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= req;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        predict_request(req);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    function automatic t_in random_request();
        t_in q;
        int sel;
        sel = $urandom_range(99);
        q.task_id = 8'($urandom);
        q.tick_value = $urandom;
        if (sel < 15) q.action = ACT_READ;
        else if (sel < 45) begin
            q.action = ACT_REL;
            if ($urandom_range(9) != 0) q.tick_value = $urandom_range(6);
        end else if (sel < 60) begin
            q.action = ACT_ABS;
            if ($urandom_range(3) != 0) q.tick_value = now_ticks + $urandom_range(6) - 1;
        end else q.action = ACT_TICK;
        return q;
    endfunction

    task automatic add_row(input t_action a, input logic [7:0] id, input logic [31:0] v,
                           input bit fx, input t_kind k, input logic [31:0] tn, input bit l);
        t_row r;
        r.req = '{a, id, v};
        r.has_fixed = fx;
        r.fixed = '{k, id, tn, l};
        rows.push_back(r);
    endtask

    initial begin
        t_in req;
        errors = 0;
        cycles = 0;
        hold_off = 0;
        draining = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        now_ticks = '0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_data = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, wrap of relative delay, past wake time, queue full
        add_row(ACT_READ, 8'hff, 32'hffff_ffff, 1, KIND_TIME, 32'd0, 1);
        add_row(ACT_TICK, 8'h00, 32'hffff_ffff, 1, KIND_ACK, 32'd1, 1);
        add_row(ACT_REL, 8'h11, 32'hffff_ffff, 0, KIND_TIME, 0, 0);
        add_row(ACT_ABS, 8'h22, 32'd0, 0, KIND_TIME, 0, 0);
        add_row(ACT_ABS, 8'h33, 32'd3, 0, KIND_TIME, 0, 0);
        add_row(ACT_REL, 8'h44, 32'd2, 0, KIND_TIME, 0, 0);
        add_row(ACT_ABS, 8'h55, 32'hffff_ffff, 0, KIND_TIME, 0, 0);
        add_row(ACT_TICK, 8'haa, 32'd0, 0, KIND_TIME, 0, 0);
        add_row(ACT_TICK, 8'h55, 32'd0, 0, KIND_TIME, 0, 0);
        for (int i = 0; i < 15; i++)
            add_row(ACT_ABS, 8'(i), 32'd5, 0, KIND_TIME, 0, 0);
        add_row(ACT_REL, 8'hee, 32'd1, 1, KIND_FULL, 32'd3, 1);
        foreach (rows[i]) begin
            if (rows[i].has_fixed) begin
                req = rows[i].req;
                send_request(req);
                if (pending_replies.size() > 0 && pending_replies[$] != rows[i].fixed) begin
                    $display("%0t: table row %0d expected %p predicted %p", $time, i,
                             rows[i].fixed, pending_replies[$]);
                    errors++;
                end
            end else begin
                send_request(rows[i].req);
            end
        end
        wait_drained();

        // Long receiver hold while requests keep coming: fill up and stall input
        hold_off = 300;
        for (int i = 0; i < 12; i++) begin
            req = '{ACT_READ, 8'(i), $urandom};
            send_request(req);
        end
        wait_drained();

        // Raise the tick count past the wake times parked at 5; the entry at 32'hffff_ffff stays
        for (int i = 0; i < 2; i++) begin
            req = '{ACT_TICK, 8'h01, 32'hffff_ffff};
            send_request(req);
        end

        // Random phases with varied idling
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 51; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 51; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            for (int i = 0; i < 16; i++)
                send_request(random_request());
            // Sender pauses until every reply is back
            wait_drained();
        end
        draining = 1'b1;
        wait_drained();

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire

FILE: files.f
design/tdwq_pkg.sv
design/tdwq_front.sv
design/tdwq_back.sv
design/tick_delay_wakeup_queue_core.sv
design/tdwq_checker.sv
test/tb.sv
